FILE: design/complex_arith_unit_macros.svh
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arith_unit: same-cycle check failed");
`define CAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_arith_unit: next-cycle check failed");
`else
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CAU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/cau_pkg.sv
// Types and constants of the complex arithmetic unit.
package cau_pkg;

    localparam int W     = 32;       // operand width
    localparam int FRAC  = 16;       // fraction bits
    localparam int DW    = 2 * W;    // product width
    localparam int FLD_W = 32;       // width of every operand and result field
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;
    localparam int IN_DATA_W  = 4 * FLD_W;
    localparam int OUT_DATA_W = ((2 * FLD_W + 1 + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NE  = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic               sat;
        logic signed [W-1:0] val;
    } t_clamp;

endpackage

FILE: design/complex_arith_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide and compare, Q16.16.
//
//  channel  | direction | tdata (low bit up)                        | tuser
//  ---------+-----------+-------------------------------------------+-----------------
//  s_axis   | in        | a_real, a_imag, b_real, b_imag            | req_type
//  m_axis   | out       | res_real, res_imag, compare_true, pad     | status
//
// One item enters per cycle unless the output stalls; an accepted item passes stages 0-3,
// the restoring divider, which resolves one quotient bit per stage, and the output
// register. Every operation travels the same stages, so order holds.
// A result waiting in the output register with m_axis_tready low freezes all
// stages together; s_axis_tready drops for that cycle.
// Reset (synchronous, active low) clears the valid bits of all stages.
`include "complex_arith_unit_macros.svh"

module complex_arith_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // a_real[31:0], a_imag[63:32], b_real[95:64], b_imag[127:96]
    input  logic [cau_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[2:0]
    input  logic [cau_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // res_real[31:0], res_imag[63:32], compare_true[64], zero pad above
    output logic [cau_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status[1:0]
    output logic [cau_pkg::ST_W-1:0]         m_axis_tuser
);
    import cau_pkg::*;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [DW-1:0] HALF   = DW'(1) << (W - 1);
    localparam logic [DW-1:0] RND    = (DW'(1) << FRAC) - DW'(1);
    localparam int NX_W = DW + FRAC;

    typedef struct packed {
        logic                vld;
        t_op                 op;
        logic signed [W-1:0] ar, ai, br, bi;
    } t_s0;

    typedef struct packed {
        logic                 vld;
        t_op                  op;
        logic signed [DW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
        logic signed [W-1:0]  pre_re, pre_im;
        logic                 pre_cmp;
        t_status              pre_st;
    } t_s1;

    typedef struct packed {
        logic                 vld;
        t_op                  op;
        logic signed [DW:0]   s_re, s_im;
        logic [DW-1:0]        den;
        logic signed [W-1:0]  pre_re, pre_im;
        logic                 pre_cmp;
        t_status              pre_st;
    } t_s2;

    typedef struct packed {
        logic                 vld;
        t_op                  op;
        logic                 neg_re, neg_im;
        logic [DW-1:0]        mag_re, mag_im, den;
        logic                 den_zero;
        logic signed [W-1:0]  pre_re, pre_im;
        logic                 pre_cmp;
        t_status              pre_st;
    } t_s3;

    typedef struct packed {
        logic                 vld;
        t_op                  op;
        logic                 neg_re, neg_im, ovf_re, ovf_im, den_zero;
        logic [DW-1:0]        den, rem_re, rem_im;
        logic [W-1:0]         q_re, q_im, n_re, n_im;
        logic signed [W-1:0]  pre_re, pre_im;
        logic                 pre_cmp;
        t_status              pre_st;
    } t_dv;

    typedef struct packed {
        logic                vld;
        logic signed [W-1:0] re, im;
        logic                cmp;
        t_status             st;
    } t_out;

    t_s0  r_s0, n_s0;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_dv  r_dv [W+1];
    t_dv  n_dv [W+1];
    t_dv  n_dv0;
    t_out r_out, n_out;

    logic          w_ce;
    logic [W+5:0]  w_vld_vec;

    function automatic t_clamp add_clamp(input logic signed [W:0] s);
        t_clamp c;
        c.sat = s[W] ^ s[W-1];
        c.val = c.sat ? (s[W] ? MINV : MAXV) : s[W-1:0];
        return c;
    endfunction

    function automatic t_clamp mul_clamp(input logic neg, input logic [DW-1:0] mag);
        t_clamp c;
        logic [DW-1:0] q;
        q = neg ? ((mag + RND) >> FRAC) : (mag >> FRAC);
        if (neg) begin
            c.sat = q > HALF;
            c.val = c.sat ? MINV : -q[W-1:0];
        end else begin
            c.sat = q > (HALF - DW'(1));
            c.val = c.sat ? MAXV : q[W-1:0];
        end
        return c;
    endfunction

    function automatic t_clamp div_clamp(input logic neg, input logic ovf,
                                         input logic [W-1:0] q);
        t_clamp c;
        if (neg) begin
            c.sat = ovf | (q[W-1] & (|q[W-2:0]));
            c.val = c.sat ? MINV : -q;
        end else begin
            c.sat = ovf | q[W-1];
            c.val = c.sat ? MAXV : q;
        end
        return c;
    endfunction

    assign w_ce          = !r_out.vld || m_axis_tready;
    assign s_axis_tready = w_ce;

    // stage 0: capture operands
    always_comb begin
        n_s0.vld = s_axis_tvalid;
        n_s0.op  = t_op'(s_axis_tuser);
        n_s0.ar  = s_axis_tdata[W-1:0];
        n_s0.ai  = s_axis_tdata[FLD_W+W-1:FLD_W];
        n_s0.br  = s_axis_tdata[2*FLD_W+W-1:2*FLD_W];
        n_s0.bi  = s_axis_tdata[3*FLD_W+W-1:3*FLD_W];
    end

    // stage 1: cross products, plus add, subtract and compare
    always_comb begin
        t_clamp        c_re, c_im;
        logic          eq;
        n_s1.vld  = r_s0.vld;
        n_s1.op   = r_s0.op;
        n_s1.p_rr = r_s0.ar * r_s0.br;
        n_s1.p_ii = r_s0.ai * r_s0.bi;
        n_s1.p_ri = r_s0.ar * r_s0.bi;
        n_s1.p_ir = r_s0.ai * r_s0.br;
        n_s1.p_bb = r_s0.br * r_s0.br;
        n_s1.p_cc = r_s0.bi * r_s0.bi;
        eq = (r_s0.ar == r_s0.br) && (r_s0.ai == r_s0.bi);
        if (r_s0.op == OP_SUB) begin
            c_re = add_clamp((W+1)'(r_s0.ar) - (W+1)'(r_s0.br));
            c_im = add_clamp((W+1)'(r_s0.ai) - (W+1)'(r_s0.bi));
        end else begin
            c_re = add_clamp((W+1)'(r_s0.ar) + (W+1)'(r_s0.br));
            c_im = add_clamp((W+1)'(r_s0.ai) + (W+1)'(r_s0.bi));
        end
        n_s1.pre_re  = '0;
        n_s1.pre_im  = '0;
        n_s1.pre_cmp = 1'b0;
        n_s1.pre_st  = ST_OK;
        case (r_s0.op)
            OP_ADD, OP_SUB: begin
                n_s1.pre_re = c_re.val;
                n_s1.pre_im = c_im.val;
                n_s1.pre_st = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
            end
            OP_EQ:   n_s1.pre_cmp = eq;
            OP_NE:   n_s1.pre_cmp = !eq;
            default: ;
        endcase
    end

    // stage 2: sums of cross terms and the denominator
    always_comb begin
        n_s2.vld     = r_s1.vld;
        n_s2.op      = r_s1.op;
        n_s2.pre_re  = r_s1.pre_re;
        n_s2.pre_im  = r_s1.pre_im;
        n_s2.pre_cmp = r_s1.pre_cmp;
        n_s2.pre_st  = r_s1.pre_st;
        if (r_s1.op == OP_MUL) begin
            n_s2.s_re = (DW+1)'(r_s1.p_rr) - (DW+1)'(r_s1.p_ii);
            n_s2.s_im = (DW+1)'(r_s1.p_ri) + (DW+1)'(r_s1.p_ir);
        end else begin
            n_s2.s_re = (DW+1)'(r_s1.p_rr) + (DW+1)'(r_s1.p_ii);
            n_s2.s_im = (DW+1)'(r_s1.p_ir) - (DW+1)'(r_s1.p_ri);
        end
        n_s2.den = $unsigned(r_s1.p_bb) + $unsigned(r_s1.p_cc);
    end

    // stage 3: sign and magnitude
    always_comb begin
        logic [DW:0] neg_re, neg_im;
        neg_re         = -r_s2.s_re;
        neg_im         = -r_s2.s_im;
        n_s3.vld       = r_s2.vld;
        n_s3.op        = r_s2.op;
        n_s3.pre_re    = r_s2.pre_re;
        n_s3.pre_im    = r_s2.pre_im;
        n_s3.pre_cmp   = r_s2.pre_cmp;
        n_s3.pre_st    = r_s2.pre_st;
        n_s3.neg_re    = r_s2.s_re[DW];
        n_s3.neg_im    = r_s2.s_im[DW];
        n_s3.mag_re    = r_s2.s_re[DW] ? neg_re[DW-1:0] : r_s2.s_re[DW-1:0];
        n_s3.mag_im    = r_s2.s_im[DW] ? neg_im[DW-1:0] : r_s2.s_im[DW-1:0];
        n_s3.den       = r_s2.den;
        n_s3.den_zero  = (r_s2.den == '0);
    end

    // stage 4: finish products, load the dividers
    always_comb begin
        t_clamp          m_re, m_im;
        logic [NX_W-1:0] nx_re, nx_im;
        m_re  = mul_clamp(r_s3.neg_re, r_s3.mag_re);
        m_im  = mul_clamp(r_s3.neg_im, r_s3.mag_im);
        nx_re = NX_W'(r_s3.mag_re) << FRAC;
        nx_im = NX_W'(r_s3.mag_im) << FRAC;
        n_dv0.vld      = r_s3.vld;
        n_dv0.op       = r_s3.op;
        n_dv0.neg_re   = r_s3.neg_re;
        n_dv0.neg_im   = r_s3.neg_im;
        n_dv0.den_zero = r_s3.den_zero;
        n_dv0.den      = r_s3.den;
        n_dv0.rem_re   = DW'(nx_re[NX_W-1:W]);
        n_dv0.rem_im   = DW'(nx_im[NX_W-1:W]);
        // quotient needs more than W bits: certain saturation
        n_dv0.ovf_re   = DW'(nx_re[NX_W-1:W]) >= r_s3.den;
        n_dv0.ovf_im   = DW'(nx_im[NX_W-1:W]) >= r_s3.den;
        n_dv0.q_re     = '0;
        n_dv0.q_im     = '0;
        n_dv0.n_re     = nx_re[W-1:0];
        n_dv0.n_im     = nx_im[W-1:0];
        n_dv0.pre_cmp  = r_s3.pre_cmp;
        if (r_s3.op == OP_MUL) begin
            n_dv0.pre_re = m_re.val;
            n_dv0.pre_im = m_im.val;
            n_dv0.pre_st = (m_re.sat || m_im.sat) ? ST_SAT : ST_OK;
        end else begin
            n_dv0.pre_re = r_s3.pre_re;
            n_dv0.pre_im = r_s3.pre_im;
            n_dv0.pre_st = r_s3.pre_st;
        end
    end

    // divider stages: one quotient bit each
    always_comb begin
        logic [DW:0] t_re, t_im;
        n_dv[0] = n_dv0;
        for (int k = 0; k < W; k++) begin
            n_dv[k+1] = r_dv[k];
            t_re = {r_dv[k].rem_re, r_dv[k].n_re[W-1]};
            t_im = {r_dv[k].rem_im, r_dv[k].n_im[W-1]};
            n_dv[k+1].n_re = r_dv[k].n_re << 1;
            n_dv[k+1].n_im = r_dv[k].n_im << 1;
            if (t_re >= {1'b0, r_dv[k].den}) begin
                n_dv[k+1].rem_re = DW'(t_re - {1'b0, r_dv[k].den});
                n_dv[k+1].q_re   = {r_dv[k].q_re[W-2:0], 1'b1};
            end else begin
                n_dv[k+1].rem_re = t_re[DW-1:0];
                n_dv[k+1].q_re   = {r_dv[k].q_re[W-2:0], 1'b0};
            end
            if (t_im >= {1'b0, r_dv[k].den}) begin
                n_dv[k+1].rem_im = DW'(t_im - {1'b0, r_dv[k].den});
                n_dv[k+1].q_im   = {r_dv[k].q_im[W-2:0], 1'b1};
            end else begin
                n_dv[k+1].rem_im = t_im[DW-1:0];
                n_dv[k+1].q_im   = {r_dv[k].q_im[W-2:0], 1'b0};
            end
        end
    end

    // output stage: pick the result of the operation
    always_comb begin
        t_clamp d_re, d_im;
        d_re = div_clamp(r_dv[W].neg_re, r_dv[W].ovf_re, r_dv[W].q_re);
        d_im = div_clamp(r_dv[W].neg_im, r_dv[W].ovf_im, r_dv[W].q_im);
        n_out.vld = r_dv[W].vld;
        n_out.cmp = r_dv[W].pre_cmp;
        if (r_dv[W].op == OP_DIV) begin
            if (r_dv[W].den_zero) begin
                n_out.re = '0;
                n_out.im = '0;
                n_out.st = ST_DIV0;
            end else begin
                n_out.re = d_re.val;
                n_out.im = d_im.val;
                n_out.st = (d_re.sat || d_im.sat) ? ST_SAT : ST_OK;
            end
        end else begin
            n_out.re = r_dv[W].pre_re;
            n_out.im = r_dv[W].pre_im;
            n_out.st = r_dv[W].pre_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld  <= 1'b0;
            r_s1.vld  <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_s3.vld  <= 1'b0;
            r_out.vld <= 1'b0;
            for (int k = 0; k <= W; k++) begin
                r_dv[k].vld <= 1'b0;
            end
        end else if (w_ce) begin
            r_s0  <= n_s0;
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_out <= n_out;
            for (int k = 0; k <= W; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    always_comb begin
        w_vld_vec[0] = r_s0.vld;
        w_vld_vec[1] = r_s1.vld;
        w_vld_vec[2] = r_s2.vld;
        w_vld_vec[3] = r_s3.vld;
        for (int k = 0; k <= W; k++) begin
            w_vld_vec[4+k] = r_dv[k].vld;
        end
        w_vld_vec[W+5] = r_out.vld;
    end

    assign m_axis_tvalid = r_out.vld;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.cmp, FLD_W'(r_out.im), FLD_W'(r_out.re)});
    assign m_axis_tuser  = r_out.st;

    `CAU_ASSERT_NXT(a_stall_freezes, i_clk, i_rst_n, !w_ce, $stable(w_vld_vec))
    `CAU_ASSERT_IMP(a_div0_zero, i_clk, i_rst_n, r_out.vld && r_out.st == ST_DIV0, r_out.re == '0 && r_out.im == '0 && !r_out.cmp)
    `CAU_ASSERT_IMP(a_cmp_clean, i_clk, i_rst_n, r_out.vld && r_out.cmp, r_out.re == '0 && r_out.im == '0 && r_out.st == ST_OK)
    `CAU_ASSERT_IMP(a_div0_from_den, i_clk, i_rst_n, r_dv[W].vld && r_dv[W].op == OP_DIV && r_dv[W].den_zero, n_out.st == ST_DIV0)

endmodule

FILE: test/tb.sv
// Self-checking testbench for the complex arithmetic unit: directed table, then random items.
module tb;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        cmp;
        logic [1:0]  st;
    } cplx_res_t;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [31:0]     ar, ai, br, bi;
        bit              known;
        cplx_res_t       res;
    } op_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // a_real, a_imag, b_real, b_imag
    logic [OP_W-1:0]        s_axis_tuser;   // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // res_real, res_imag, compare_true, pad
    logic [ST_W-1:0]        m_axis_tuser;   // status

    cplx_res_t results_due[$];
    int        n_errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        stim_done;

    complex_arith_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] saturate(input logic signed [127:0] v, inout bit sat);
        if (v > 128'sh7fffffff) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sh80000000) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // quotient truncated toward zero
    function automatic logic [31:0] div_part(input logic signed [127:0] num,
                                             input logic signed [127:0] den, inout bit sat);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FRAC) / den;
        return saturate((num < 0) ? -q : q, sat);
    endfunction

    function automatic cplx_res_t complex_result(input logic [OP_W-1:0] op,
                                                 input logic [31:0] ar_u, ai_u, br_u, bi_u);
        cplx_res_t r;
        bit sat;
        logic signed [127:0] ar, ai, br, bi, den;
        ar = signed'(ar_u);
        ai = signed'(ai_u);
        br = signed'(br_u);
        bi = signed'(bi_u);
        r = '{re: '0, im: '0, cmp: 1'b0, st: ST_OK};
        sat = 1'b0;
        case (op)
            OP_ADD: begin
                r.re = saturate(ar + br, sat);
                r.im = saturate(ai + bi, sat);
            end
            OP_SUB: begin
                r.re = saturate(ar - br, sat);
                r.im = saturate(ai - bi, sat);
            end
            OP_MUL: begin
                r.re = saturate((ar * br - ai * bi) >>> FRAC, sat);
                r.im = saturate((ar * bi + ai * br) >>> FRAC, sat);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.st = ST_DIV0;
                end else begin
                    r.re = div_part(ar * br + ai * bi, den, sat);
                    r.im = div_part(ai * br - ar * bi, den, sat);
                end
            end
            OP_EQ: r.cmp = (ar == br && ai == bi);
            OP_NE: r.cmp = !(ar == br && ai == bi);
            default: ;
        endcase
        if (sat) r.st = ST_SAT;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(6))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return $urandom_range(262143) - 131072;
            4: return ($urandom_range(15) - 8) << FRAC;
            default: return $urandom;
        endcase
    endfunction

    op_row_t directed[] = '{
        '{OP_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000, 0, '{0, 0, 0, 0}},
        '{OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1,
          '{32'h7fffffff, 32'h7fffffff, 1'b0, ST_SAT}},
        '{OP_SUB, 32'h80000000, 32'h0, 32'h1, 32'h0, 1,
          '{32'h80000000, 32'h0, 1'b0, ST_SAT}},
        '{OP_SUB, 32'h12345678, 32'hfedcba98, 32'h00000001, 32'h80000000, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 32'h00010000, 32'h0, 32'h00020000, 32'h00030000, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 32'hffffffff, 32'h0, 32'h00000001, 32'h0, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 1,
          '{32'h0, 32'h0, 1'b0, ST_DIV0}},
        '{OP_DIV, 32'h00010000, 32'h0, 32'h00010000, 32'h0, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 32'hfffe0000, 32'h00010000, 32'h00030000, 32'hffff0000, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, '{0, 0, 0, 0}},
        '{OP_EQ, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1,
          '{32'h0, 32'h0, 1'b1, ST_OK}},
        '{OP_EQ, 32'h1, 32'h2, 32'h1, 32'h3, 1, '{32'h0, 32'h0, 1'b0, ST_OK}},
        '{OP_NE, 32'h5, 32'h6, 32'h5, 32'h6, 1, '{32'h0, 32'h0, 1'b0, ST_OK}},
        '{OP_NE, 32'h0, 32'h0, 32'h0, 32'h1, 1, '{32'h0, 32'h0, 1'b1, ST_OK}},
        '{OP_RSVD6, 32'h7fffffff, 32'h1, 32'h7fffffff, 32'h1, 1, '{32'h0, 32'h0, 1'b0, ST_OK}},
        '{OP_RSVD7, 32'h0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 1'b0, ST_OK}}
    };

    // hold the item until the block takes it, then log its expected result
    task automatic send_item(input op_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.op;
        s_axis_tdata  <= {row.bi, row.br, row.ai, row.ar};
        do @(posedge i_clk); while (!s_axis_tready);
        results_due.push_back(row.known ? row.res
                              : complex_result(row.op, row.ar, row.ai, row.br, row.bi));
    endtask

    initial begin
        op_row_t row;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        n_errors       = 0;
        stim_done      = 0;
        send_idle_pct  = 16;
        recv_stall_pct = 85;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_item(directed[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct  = 85;
                recv_stall_pct = 16;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            row.op    = ($urandom_range(19) == 0) ? $urandom_range(7, 6) : $urandom_range(5);
            row.ar    = pick_operand();
            row.ai    = pick_operand();
            row.br    = pick_operand();
            row.bi    = pick_operand();
            row.known = 0;
            row.res   = '{0, 0, 0, 0};
            // equal operands make compares and subtracts interesting
            if ($urandom_range(3) == 0) begin
                row.br = row.ar;
                row.bi = row.ai;
            end
            send_item(row);
        end
        s_axis_tvalid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // check each accepted result against the oldest expected one
    always @(posedge i_clk) begin
        cplx_res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result: tdata %h", m_axis_tdata);
            end else begin
                want = results_due.pop_front();
                if (m_axis_tdata[31:0] !== want.re || m_axis_tdata[63:32] !== want.im ||
                    m_axis_tdata[64] !== want.cmp || m_axis_tuser !== want.st) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp re %h im %h cmp %b st %0d, got re %h im %h cmp %b st %0d",
                                 want.re, want.im, want.cmp, want.st, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tdata[64], m_axis_tuser);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial m_axis_tready = 1'b0;

endmodule
